// File: rtl/qoi_pkg.sv
// Shared types, constants and helpers for the QOI-variant pixel decoder.
// No dependencies; every other rtl file but qoi_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qoi_pkg;

    // color cache geometry, fixed by the hash of the format
    localparam int CACHE_ENTRIES = 64;
    localparam int CACHE_AW      = 6;
    localparam int COLOR_W       = 32;

    // depth of the result queue in front of the master side
    localparam int RES_DEPTH = 3;
    localparam int RES_CW    = 2;

    // configuration register indexes (paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // input kinds carried on s_tuser
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // op tags of the first byte
    localparam logic [1:0] TAG_INDEX  = 2'b00;
    localparam logic [1:0] TAG_DIFF   = 2'b10;
    localparam logic [2:0] TAG_RUN8   = 3'b010;
    localparam logic [2:0] TAG_RUN16  = 3'b011;
    localparam logic [2:0] TAG_LUMA   = 3'b110;
    localparam logic [3:0] TAG_DELTA4 = 4'b1110;
    localparam logic [3:0] TAG_RAW    = 4'b1111;

    // extra offset of the two-byte run
    localparam logic [13:0] RUN16_BIAS = 14'd33;

    // reset color: rgb zero, alpha opaque
    localparam logic [COLOR_W-1:0] COLOR_RESET = 32'h0000_00FF;

    // cache write request from the decode stage
    typedef struct packed {
        logic                    en;
        logic [CACHE_AW-1:0]     addr;
        logic [COLOR_W-1:0]      data;
    } qoi_cache_wr_t;

    // one result item
    typedef struct packed {
        logic        done;
        logic        status;
        logic [31:0] rep;
        logic [7:0]  alpha;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } qoi_result_t;

    // wrapping channel adds with sign-extended deltas
    function automatic logic [7:0] add_d2(logic [7:0] c, logic [1:0] f);
        return c + {{6{f[1]}}, f};
    endfunction

    function automatic logic [7:0] add_d4(logic [7:0] c, logic [3:0] f);
        return c + {{4{f[3]}}, f};
    endfunction

    function automatic logic [7:0] add_d5(logic [7:0] c, logic [4:0] f);
        return c + {{3{f[4]}}, f};
    endfunction

    // cache slot of a color packed r,g,b,a from the top byte down
    function automatic logic [CACHE_AW-1:0] color_hash(logic [COLOR_W-1:0] c);
        logic [7:0] x;
        x = c[31:24] ^ c[23:16] ^ c[15:8] ^ c[7:0];
        return x[CACHE_AW-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/qoi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module qoi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/qoi_res_fifo.sv
// Small result queue that registers the master side of the decoder.
// Depends on qoi_pkg for the result type and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module qoi_res_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire qoi_pkg::qoi_result_t push_data,
    input  wire logic                 pop,
    output logic                      not_empty,
    output qoi_pkg::qoi_result_t      head,
    output logic [qoi_pkg::RES_CW-1:0] count
);
    import qoi_pkg::*;

    qoi_result_t          slot_reg [RES_DEPTH];
    logic [RES_CW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [RES_CW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [RES_CW-1:0]    cnt_reg, cnt_next;

    // pointer wrap at the queue depth
    function automatic logic [RES_CW-1:0] ptr_inc(logic [RES_CW-1:0] p);
        return (p == RES_CW'(RES_DEPTH - 1)) ? '0 : p + RES_CW'(1);
    endfunction

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + RES_CW'(push) - RES_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign count     = cnt_reg;

endmodule

`default_nettype wire

// File: rtl/qoi_dec_core.sv
// Decode stage: op state, current color, pixel count and cache valid bits,
// with forwarding around the cache RAM. Depends on qoi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qoi_dec_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_accept,
    input  wire logic                          in_kind,
    input  wire logic [7:0]                    in_byte,
    input  wire logic [31:0]                   total,
    input  wire logic [qoi_pkg::COLOR_W-1:0]   rd_data,
    output qoi_pkg::qoi_cache_wr_t             cache_wr,
    output logic                               res_valid,
    output qoi_pkg::qoi_result_t               res,
    output logic                               busy
);
    import qoi_pkg::*;

    // decode stage registers
    logic                    s1_vld_reg;
    logic                    s1_kind_reg;
    logic [7:0]              s1_byte_reg;
    logic                    s1_hit_reg, s1_hit_next;
    logic                    s1_fwd_reg, s1_fwd_next;
    logic [COLOR_W-1:0]      s1_fwd_data_reg;

    // decoder state
    logic [COLOR_W-1:0]      cur_reg, cur_next;
    logic [7:0]              pop_reg, pop_next;
    logic [7:0]              psec_reg, psec_next;
    logic [2:0]              await_reg, await_next;
    logic [31:0]             given_reg, given_next;
    logic [CACHE_ENTRIES-1:0] vld_reg, vld_next;

    logic [COLOR_W-1:0]      entry;
    logic [31:0]             left;
    logic [31:0]             rep;
    logic [13:0]             cnt;
    logic                    fin;
    logic                    clear_now;
    logic [COLOR_W-1:0]      col;
    logic [7:0]              b;
    logic [7:0]              p;
    logic [2:0]              await_dec;
    logic [23:0]             merged;

    assign b         = s1_byte_reg;
    assign p         = pop_reg;
    assign clear_now = s1_vld_reg && (s1_kind_reg == KIND_END);
    assign busy      = s1_vld_reg;

    // cache entry as seen by this item, unwritten slots read as zero
    assign entry = s1_fwd_reg ? s1_fwd_data_reg : (s1_hit_reg ? rd_data : '0);

    // pixels still open in the image
    assign left = (given_reg >= total) ? '0 : total - given_reg;

    assign await_dec = await_reg - 3'd1;
    assign merged    = {p, psec_reg, b};

    // op decode and color update
    always_comb begin
        col        = cur_reg;
        cnt        = 14'd1;
        fin        = 1'b0;
        pop_next   = pop_reg;
        psec_next  = psec_reg;
        await_next = await_reg;
        if (s1_vld_reg && (s1_kind_reg == KIND_BYTE) && (left != '0)) begin
            if (await_reg == 3'd0) begin
                if (b[7:6] == TAG_INDEX) begin
                    col = entry;
                    fin = 1'b1;
                end else if (b[7:5] == TAG_RUN8) begin
                    cnt = {9'd0, b[4:0]} + 14'd1;
                    fin = 1'b1;
                end else if (b[7:6] == TAG_DIFF) begin
                    col[31:24] = add_d2(cur_reg[31:24], b[5:4]);
                    col[23:16] = add_d2(cur_reg[23:16], b[3:2]);
                    col[15:8]  = add_d2(cur_reg[15:8], b[1:0]);
                    fin        = 1'b1;
                end else begin
                    pop_next = b;
                    if ((b[7:5] == TAG_RUN16) || (b[7:5] == TAG_LUMA)) begin
                        await_next = 3'd1;
                    end else if (b[7:4] == TAG_DELTA4) begin
                        await_next = 3'd2;
                    end else begin
                        // raw channels: one byte per set flag
                        await_next = {2'd0, b[3]} + {2'd0, b[2]} + {2'd0, b[1]} + {2'd0, b[0]};
                        fin        = (b[3:0] == 4'd0);
                    end
                end
            end else begin
                if (p[7:5] == TAG_RUN16) begin
                    cnt = {p[4:0], b} + RUN16_BIAS;
                    fin = 1'b1;
                end else if (p[7:5] == TAG_LUMA) begin
                    col[31:24] = add_d5(cur_reg[31:24], p[4:0]);
                    col[23:16] = add_d4(cur_reg[23:16], b[7:4]);
                    col[15:8]  = add_d4(cur_reg[15:8], b[3:0]);
                    fin        = 1'b1;
                end else if (p[7:4] == TAG_DELTA4) begin
                    if (await_reg >= 3'd2) begin
                        psec_next  = b;
                        await_next = 3'd1;
                    end else begin
                        col[31:24] = add_d5(cur_reg[31:24], merged[19:15]);
                        col[23:16] = add_d5(cur_reg[23:16], merged[14:10]);
                        col[15:8]  = add_d5(cur_reg[15:8], merged[9:5]);
                        col[7:0]   = add_d5(cur_reg[7:0], merged[4:0]);
                        fin        = 1'b1;
                    end
                end else if (p[7:4] == TAG_RAW) begin
                    // highest pending flag takes this byte
                    priority if (p[3]) begin
                        col[31:24] = b;
                        pop_next   = {p[7:4], 1'b0, p[2:0]};
                    end else if (p[2]) begin
                        col[23:16] = b;
                        pop_next   = {p[7:3], 1'b0, p[1:0]};
                    end else if (p[1]) begin
                        col[15:8] = b;
                        pop_next  = {p[7:2], 1'b0, p[0]};
                    end else if (p[0]) begin
                        col[7:0] = b;
                        pop_next = {p[7:1], 1'b0};
                    end else begin
                        pop_next = p;
                    end
                    await_next = await_dec;
                    fin        = (await_dec == 3'd0) || (pop_next[3:0] == 4'd0);
                end else begin
                    await_next = 3'd0;
                    pop_next   = '0;
                end
            end
        end
        if (fin) begin
            pop_next   = '0;
            psec_next  = '0;
            await_next = 3'd0;
        end
    end

    // repeat count clipped to what is left
    assign rep = ({18'd0, cnt} < left) ? {18'd0, cnt} : left;

    // state update, end marker returns everything to reset
    always_comb begin
        cur_next   = cur_reg;
        given_next = given_reg;
        vld_next   = vld_reg;
        if (clear_now) begin
            cur_next   = COLOR_RESET;
            given_next = '0;
            vld_next   = '0;
        end else begin
            cur_next = col;
            if (fin) begin
                given_next = given_reg + rep;
                vld_next[color_hash(col)] = 1'b1;
            end
        end
    end

    // cache write back and result
    always_comb begin
        cache_wr.en   = fin && !clear_now;
        cache_wr.addr = color_hash(col);
        cache_wr.data = col;
        res_valid     = fin || clear_now;
        res.done      = clear_now;
        res.status    = clear_now && (await_reg != 3'd0);
        if (clear_now && (await_reg != 3'd0)) begin
            res.rep   = '0;
            res.red   = '0;
            res.green = '0;
            res.blue  = '0;
            res.alpha = '0;
        end else begin
            res.rep   = clear_now ? left : rep;
            res.red   = col[31:24];
            res.green = col[23:16];
            res.blue  = col[15:8];
            res.alpha = col[7:0];
        end
    end

    // forwarding for the read issued this cycle
    always_comb begin
        s1_fwd_next = cache_wr.en && (cache_wr.addr == in_byte[CACHE_AW-1:0]);
        s1_hit_next = !clear_now && (vld_reg[in_byte[CACHE_AW-1:0]] || s1_fwd_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            cur_reg    <= COLOR_RESET;
            pop_reg    <= '0;
            psec_reg   <= '0;
            await_reg  <= '0;
            given_reg  <= '0;
            vld_reg    <= '0;
        end else begin
            s1_vld_reg <= in_accept;
            cur_reg    <= cur_next;
            pop_reg    <= clear_now ? '0 : pop_next;
            psec_reg   <= clear_now ? '0 : psec_next;
            await_reg  <= clear_now ? '0 : await_next;
            given_reg  <= given_next;
            vld_reg    <= vld_next;
        end
    end

    // item payload into the decode stage
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_kind_reg     <= in_kind;
            s1_byte_reg     <= in_byte;
            s1_hit_reg      <= s1_hit_next;
            s1_fwd_reg      <= s1_fwd_next;
            s1_fwd_data_reg <= cache_wr.data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/qoi_variant_pixel_decoder_unit.sv
// QOI-variant pixel decoder: top level with APB registers, cache RAM,
// decode stage and result queue. Depends on qoi_pkg, qoi_ram, qoi_dec_core, qoi_res_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Decodes one payload byte per cycle while the queue has room. A byte is accepted on s_*,
// its cache slot is read from a 64x32 synchronous RAM in that cycle, and the next cycle
// decodes the op, updates the current color and writes the cache back, with forwarding
// when the following byte reads the slot just written. A result leaves through a
// three-entry queue, so an item passes the decode stage registers and a queue slot to
// reach m_*, and the input keeps taking one byte per cycle while the queue has room.
// Leading bytes of a multi-byte op and bytes after the image is full give no item; the
// end marker (s_tuser = 1) gives one item with m_tlast set and clears the decoder state,
// cache included, in the same cycle. Width and height are to be written through APB only
// while the block is idle; the block itself does not enforce it.
module qoi_variant_pixel_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] opcode
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,   // red, green, blue, alpha, repeat_res [63:32]
    output logic             m_tuser,   // [0] status
    output logic             m_tlast    // image_done
);
    import qoi_pkg::*;

    logic [15:0]         width_reg;
    logic [15:0]         height_reg;
    logic [31:0]         total_reg;
    logic                cfg_wr;
    logic                s_accept;
    logic                m_accept;
    logic                core_busy;
    logic                res_valid;
    qoi_result_t         res;
    qoi_result_t         head;
    qoi_cache_wr_t       cache_wr;
    logic [COLOR_W-1:0]  rd_data;
    logic [RES_CW-1:0]   fifo_cnt;
    logic [RES_CW:0]     in_flight;

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[15:0];
                REG_HEIGHT: height_reg <= pwdata[15:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = {16'd0, width_reg};
            REG_HEIGHT: prdata = {16'd0, height_reg};
            default:    prdata = '0;
        endcase
    end

    // pixel total, registered behind the multiplier
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= 32'd1;
        end else begin
            total_reg <= {16'd0, width_reg} * {16'd0, height_reg};
        end
    end

    // accept only while the queue can hold every item in flight
    assign in_flight = {1'b0, fifo_cnt} + {{RES_CW{1'b0}}, core_busy};
    assign s_tready  = (in_flight < (RES_CW + 1)'(RES_DEPTH));
    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_tvalid && m_tready;

    // color cache
    qoi_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_cache (
        .clk   (aclk),
        .we    (cache_wr.en),
        .waddr (cache_wr.addr),
        .wdata (cache_wr.data),
        .re    (s_accept),
        .raddr (s_tdata[CACHE_AW-1:0]),
        .rdata (rd_data)
    );

    // decode stage
    qoi_dec_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_kind   (s_tuser),
        .in_byte   (s_tdata),
        .total     (total_reg),
        .rd_data   (rd_data),
        .cache_wr  (cache_wr),
        .res_valid (res_valid),
        .res       (res),
        .busy      (core_busy)
    );

    // result queue
    qoi_res_fifo u_res_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_accept),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (fifo_cnt)
    );

    assign m_tdata = {head.rep, head.alpha, head.blue, head.green, head.red};
    assign m_tuser = head.status;
    assign m_tlast = head.done;

endmodule

`default_nettype wire

// File: test/qoi_variant_pixel_decoder_unit_tb.sv
// Self-checking testbench for the QOI-variant pixel decoder unit.
// Depends on qoi_pkg and the rtl of qoi_variant_pixel_decoder_unit.
`timescale 1ns / 1ps

module qoi_variant_pixel_decoder_unit_tb;
    import qoi_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 1350;
    localparam int CALM_ITEMS   = 200;
    localparam int DRAIN_CYCLES = 12;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    qoi_variant_pixel_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // decoder shadow state
    logic [31:0]  color_now;
    logic [31:0]  color_tbl [CACHE_ENTRIES];
    logic [7:0]   op_hold;
    logic [7:0]   second_hold;
    int unsigned  bytes_owed;
    logic [31:0]  pixels_out;
    logic [15:0]  reg_w;
    logic [15:0]  reg_h;

    qoi_result_t  runs_due [$];
    qoi_result_t  got_run;
    qoi_result_t  want_run;

    int unsigned  fail_count      = 0;
    int unsigned  items_sent      = 0;
    int unsigned  useful_items    = 0;
    int unsigned  results_checked = 0;
    int unsigned  images_closed   = 0;
    int unsigned  truncated_ends  = 0;
    int unsigned  cycle_count     = 0;
    int unsigned  stall_left      = 0;
    bit           gaps_on         = 1'b0;
    bit           stall_on        = 1'b0;

    function automatic void clear_decoder();
        color_now   = COLOR_RESET;
        foreach (color_tbl[i]) color_tbl[i] = '0;
        op_hold     = '0;
        second_hold = '0;
        bytes_owed  = 0;
        pixels_out  = '0;
    endfunction

    function automatic logic [31:0] left_px();
        logic [31:0] total;
        total = 32'(reg_w) * 32'(reg_h);
        return (pixels_out >= total) ? 32'd0 : total - pixels_out;
    endfunction

    // channel plus a signed delta of the given width, wrapping
    function automatic logic [7:0] wrap_add(logic [7:0] c, logic [4:0] field, int bits);
        int f;
        f = int'(field);
        if (f >= (1 << (bits - 1)))
            f -= (1 << bits);
        return c + 8'(f);
    endfunction

    function automatic qoi_result_t color_result(logic [31:0] rep);
        qoi_result_t r;
        r        = '0;
        r.red    = color_now[31:24];
        r.green  = color_now[23:16];
        r.blue   = color_now[15:8];
        r.alpha  = color_now[7:0];
        r.rep    = rep;
        return r;
    endfunction

    // completed op: clip, store in cache, advance pixel count
    function automatic qoi_result_t close_op(int unsigned count);
        logic [5:0]  slot;
        logic [31:0] avail;
        logic [31:0] rep;
        slot  = 6'(color_now[31:24] ^ color_now[23:16] ^ color_now[15:8] ^ color_now[7:0]);
        avail = left_px();
        rep   = (count < avail) ? count : avail;
        color_tbl[slot] = color_now;
        pixels_out  += rep;
        op_hold      = '0;
        second_hold  = '0;
        bytes_owed   = 0;
        return color_result(rep);
    endfunction

    // expected result of one input item; dropped marks an ignored byte
    function automatic bit decode_expected(input logic kind, input logic [7:0] b,
                                           output qoi_result_t res, output bit dropped);
        logic [7:0]  p;
        logic [23:0] merged;
        bit          hit;
        res     = '0;
        dropped = 1'b0;
        if (kind == KIND_END) begin
            if (bytes_owed != 0) begin
                res.status = 1'b1;
            end else begin
                res = color_result(left_px());
            end
            res.done = 1'b1;
            clear_decoder();
            return 1'b1;
        end
        if (left_px() == 0) begin
            dropped = 1'b1;
            return 1'b0;
        end
        // first byte of an op
        if (bytes_owed == 0) begin
            if (b[7:6] == TAG_INDEX) begin
                color_now = color_tbl[b[5:0]];
                res = close_op(1);
                return 1'b1;
            end
            if (b[7:5] == TAG_RUN8) begin
                res = close_op(b[4:0] + 1);
                return 1'b1;
            end
            if (b[7:6] == TAG_DIFF) begin
                color_now[31:24] = wrap_add(color_now[31:24], 5'(b[5:4]), 2);
                color_now[23:16] = wrap_add(color_now[23:16], 5'(b[3:2]), 2);
                color_now[15:8]  = wrap_add(color_now[15:8], 5'(b[1:0]), 2);
                res = close_op(1);
                return 1'b1;
            end
            op_hold = b;
            if (b[7:5] == TAG_RUN16 || b[7:5] == TAG_LUMA) begin
                bytes_owed = 1;
            end else if (b[7:4] == TAG_DELTA4) begin
                bytes_owed = 2;
            end else begin
                bytes_owed = $countones(b[3:0]);
                if (bytes_owed == 0) begin
                    res = close_op(1);
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        // follow-on byte of an open op
        p = op_hold;
        if (p[7:5] == TAG_RUN16) begin
            res = close_op({p[4:0], b} + 33);
            return 1'b1;
        end
        if (p[7:5] == TAG_LUMA) begin
            color_now[31:24] = wrap_add(color_now[31:24], p[4:0], 5);
            color_now[23:16] = wrap_add(color_now[23:16], 5'(b[7:4]), 4);
            color_now[15:8]  = wrap_add(color_now[15:8], 5'(b[3:0]), 4);
            res = close_op(1);
            return 1'b1;
        end
        if (p[7:4] == TAG_DELTA4) begin
            if (bytes_owed >= 2) begin
                second_hold = b;
                bytes_owed  = 1;
                return 1'b0;
            end
            merged = {p, second_hold, b};
            color_now[31:24] = wrap_add(color_now[31:24], merged[19:15], 5);
            color_now[23:16] = wrap_add(color_now[23:16], merged[14:10], 5);
            color_now[15:8]  = wrap_add(color_now[15:8], merged[9:5], 5);
            color_now[7:0]   = wrap_add(color_now[7:0], merged[4:0], 5);
            res = close_op(1);
            return 1'b1;
        end
        if (p[7:4] == TAG_RAW) begin
            // highest flag first: red, green, blue, alpha
            hit = 1'b0;
            for (int i = 3; i >= 0; i--) begin
                if (!hit && p[i]) begin
                    color_now[8*i +: 8] = b;
                    op_hold[i] = 1'b0;
                    hit = 1'b1;
                end
            end
            bytes_owed--;
            if (bytes_owed == 0 || op_hold[3:0] == 4'h0) begin
                res = close_op(1);
                return 1'b1;
            end
            return 1'b0;
        end
        bytes_owed = 0;
        op_hold    = '0;
        return 1'b0;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_run.red    = m_tdata[7:0];
            got_run.green  = m_tdata[15:8];
            got_run.blue   = m_tdata[23:16];
            got_run.alpha  = m_tdata[31:24];
            got_run.rep    = m_tdata[63:32];
            got_run.status = m_tuser;
            got_run.done   = m_tlast;
            if (runs_due.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %h/%b/%b",
                         $time, m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                want_run = runs_due.pop_front();
                check_field("red", want_run.red, got_run.red);
                check_field("green", want_run.green, got_run.green);
                check_field("blue", want_run.blue, got_run.blue);
                check_field("alpha", want_run.alpha, got_run.alpha);
                check_field("repeat", want_run.rep, got_run.rep);
                check_field("status", want_run.status, got_run.status);
                check_field("image_done", want_run.done, got_run.done);
                results_checked++;
                if (want_run.done) images_closed++;
                if (want_run.status) truncated_ends++;
            end
        end
    end

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (!stall_on) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // send one item and record what it should produce
    task automatic send_item(logic kind, logic [7:0] value);
        qoi_result_t res;
        bit          has_res;
        bit          dropped;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do @(posedge aclk); while (s_tready !== 1'b1);
        has_res = decode_expected(kind, value, res, dropped);
        if (has_res) runs_due.push_back(res);
        items_sent++;
        if (!dropped) useful_items++;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic send_bytes(logic [7:0] seq [$]);
        foreach (seq[i]) send_item(KIND_BYTE, seq[i]);
    endtask

    // let every expected result arrive and the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (runs_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // apb write then read back
    task automatic write_reg(logic idx, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (idx == REG_WIDTH) reg_w = value;
        else reg_h = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        check_field(idx == REG_WIDTH ? "image_width" : "image_height", {16'h0000, value},
                    prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_size(logic [15:0] w, logic [15:0] h);
        settle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // every op kind but the two-byte run on a 4x4 image, ending in a clipped run and a full image
    task automatic test_every_op();
        set_size(16'd4, 16'd4);
        send_bytes('{8'h00, 8'h40, 8'h80, 8'hBF, 8'hC0, 8'h88, 8'hDF, 8'hFF,
                     8'hE0, 8'h00, 8'h00, 8'hEF, 8'hFF, 8'hFF,
                     8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'hF0, 8'hF5, 8'hAA, 8'h00,
                     8'h3F, 8'h5F, 8'h00});
        send_item(KIND_END, 8'h5A);
    endtask

    // end marker inside each multi-byte op, on the largest image
    task automatic test_truncated_ends();
        set_size(16'hFFFF, 16'hFFFF);
        send_item(KIND_END, 8'hFF);
        send_bytes('{8'h7F});
        send_item(KIND_END, 8'h00);
        send_bytes('{8'hE5, 8'h12});
        send_item(KIND_END, 8'h81);
        send_bytes('{8'hFF, 8'h01});
        send_item(KIND_END, 8'h7E);
        send_bytes('{8'hC3});
        send_item(KIND_END, 8'h18);
        send_bytes('{8'h6A, 8'h00, 8'h7F, 8'hFF});
        send_item(KIND_END, 8'hE7);
    endtask

    // zero-sized images and the reset size of one pixel
    task automatic test_zero_and_full();
        set_size(16'd0, 16'd7);
        send_bytes('{8'h80, 8'hFF, 8'h41});
        send_item(KIND_END, 8'h00);
        set_size(16'd1, 16'd0);
        send_bytes('{8'h5F});
        send_item(KIND_END, 8'hFF);
        set_size(16'd1, 16'd1);
        send_bytes('{8'hBF, 8'h55});
        send_item(KIND_END, 8'h3C);
    endtask

    // size shrunk below and grown above the pixels already given
    task automatic test_resize_mid_image();
        set_size(16'd8, 16'd8);
        send_bytes('{8'h5F, 8'h4F});
        set_size(16'd8, 16'd4);
        send_bytes('{8'h80});
        send_item(KIND_END, 8'h11);
        set_size(16'd8, 16'd2);
        send_bytes('{8'h49});
        set_size(16'd8, 16'hFFFF);
        send_bytes('{8'h7F, 8'hFF, 8'h9A});
        send_item(KIND_END, 8'h22);
    endtask

    // one well-formed op with random content, or noise, or a cut-off op
    task automatic send_random_op();
        int         pick;
        logic [7:0] b1;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            if ($urandom_range(0, 1))
                b1 = {TAG_INDEX, 6'(color_now[31:24] ^ color_now[23:16] ^
                                    color_now[15:8] ^ color_now[7:0])};
            else
                b1 = {TAG_INDEX, 6'($urandom)};
            send_item(KIND_BYTE, b1);
        end else if (pick < 24) begin
            send_item(KIND_BYTE, {TAG_RUN8, 5'($urandom)});
        end else if (pick < 28) begin
            b1 = {TAG_RUN16, $urandom_range(0, 1) ? 5'd0 : 5'($urandom)};
            send_bytes('{b1, 8'($urandom)});
        end else if (pick < 46) begin
            send_item(KIND_BYTE, {TAG_DIFF, 6'($urandom)});
        end else if (pick < 62) begin
            send_bytes('{{TAG_LUMA, 5'($urandom)}, 8'($urandom)});
        end else if (pick < 76) begin
            send_bytes('{{TAG_DELTA4, 4'($urandom)}, 8'($urandom), 8'($urandom)});
        end else if (pick < 92) begin
            b1 = {TAG_RAW, 4'($urandom)};
            send_item(KIND_BYTE, b1);
            repeat ($countones(b1[3:0])) send_item(KIND_BYTE, 8'($urandom));
        end else if (pick < 96) begin
            send_item(KIND_BYTE, 8'($urandom));
        end else begin
            // op cut off by the end marker
            case ($urandom_range(0, 3))
                0: b1 = {TAG_RUN16, 5'($urandom)};
                1: b1 = {TAG_LUMA, 5'($urandom)};
                2: b1 = {TAG_DELTA4, 4'($urandom)};
                default: b1 = {TAG_RAW, 4'($urandom_range(3, 15))};
            endcase
            send_item(KIND_BYTE, b1);
            if ((b1[7:4] == TAG_DELTA4 || $countones(b1[3:0]) >= 2) && $urandom_range(0, 1)
                && b1[7:5] != TAG_RUN16 && b1[7:5] != TAG_LUMA)
                send_item(KIND_BYTE, 8'($urandom));
            send_item(KIND_END, 8'($urandom));
        end
    endtask

    // random phases of sizes, idling and op streams
    task automatic test_random_streams();
        int          budget;
        logic [15:0] w;
        logic [15:0] h;
        while (useful_items < ITEM_TARGET) begin
            case ($urandom_range(0, 11))
                0: begin w = 16'hFFFF; h = 16'hFFFF; end
                1: begin w = 16'd1; h = 16'd1; end
                2: begin w = 16'hFFFF; h = 16'($urandom_range(1, 3)); end
                3: begin w = 16'($urandom_range(1, 3)); h = 16'hFFFF; end
                4: begin w = 16'd0; h = 16'($urandom); end
                default: begin
                    w = 16'($urandom_range(1, 20));
                    h = 16'($urandom_range(1, 20));
                end
            endcase
            set_size(w, h);
            if (useful_items + CALM_ITEMS >= ITEM_TARGET) begin
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end else begin
                gaps_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            budget = $urandom_range(30, 90);
            repeat (budget) begin
                if (left_px() == 0 || $urandom_range(0, 39) == 0)
                    send_item(KIND_END, 8'($urandom));
                else
                    send_random_op();
            end
        end
    endtask

    // run watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, runs_due.size());
        $display("qoi_variant_pixel_decoder_unit_tb NOT OK");
        $finish;
    end

    // main sequence
    initial begin
        reg_w = 16'd1;
        reg_h = 16'd1;
        clear_decoder();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gaps_on  = 1'b1;
        stall_on = 1'b1;
        test_every_op();
        test_truncated_ends();
        test_zero_and_full();
        test_resize_mid_image();
        test_random_streams();

        s_tvalid <= 1'b0;
        while (runs_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d items (%0d decoded, rest ignored), checked %0d results",
                 items_sent, useful_items, results_checked);
        $display("closed %0d images, %0d of them cut off inside an op",
                 images_closed, truncated_ends);
        if (fail_count == 0)
            $display("qoi_variant_pixel_decoder_unit_tb OK");
        else
            $display("qoi_variant_pixel_decoder_unit_tb NOT OK");
        $finish;
    end

endmodule

// File: qoi_variant_pixel_decoder_unit.f
rtl/qoi_pkg.sv
rtl/qoi_ram.sv
rtl/qoi_res_fifo.sv
rtl/qoi_dec_core.sv
rtl/qoi_variant_pixel_decoder_unit.sv
test/qoi_variant_pixel_decoder_unit_tb.sv
